// ===== hdl/slmd_pkg.sv =====
// Shared types, command codes and sizes for the sorted list merge unit.
`timescale 1ns / 1ps

package slmd_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W = 2;
  localparam int DEFAULT_LIST_DEPTH = 32;

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      last;
    logic                      overflow;
  } result_t;

  // Outcome of comparing the two list heads.
  typedef struct packed {
    logic b_less;
    logic a_less;
  } cmp_res_t;

endpackage

// ===== hdl/slmd_list_ram.sv =====
// Single list store: one write port and one registered read port.
`timescale 1ns / 1ps

module slmd_list_ram #(
  parameter int DEPTH  = slmd_pkg::DEFAULT_LIST_DEPTH,
  parameter int ADDR_W = 5
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [slmd_pkg::VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [slmd_pkg::VALUE_W-1:0] rd_data
);
  import slmd_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/slmd_cmp.sv =====
// Shared signed comparator for the two list heads.
`timescale 1ns / 1ps

module slmd_cmp (
  input  logic [slmd_pkg::VALUE_W-1:0] head_a,
  input  logic [slmd_pkg::VALUE_W-1:0] head_b,
  output slmd_pkg::cmp_res_t           res
);
  import slmd_pkg::*;

  // Two's complement ordering of the stored bit patterns.
  always_comb begin
    res.b_less = $signed(head_b) < $signed(head_a);
    res.a_less = $signed(head_a) < $signed(head_b);
  end

endmodule

// ===== hdl/sorted_list_merge_dedup_unit.sv =====
// Top level: two sorted lists, appended one beat at a time and merged on request.
//
//   Channel   Direction  Beat type  Handshake
//   item      in         item_t     item_valid / item_stall
//   result    out        result_t   result_valid / result_stall
//
// The next item may follow an append directly.
// A merge produces each result beat in two steps: a fetch state for the registered
// read of both list stores, then an emit state for the shared compare and emit,
// which waits while the output is stalled. item_stall stays high for the whole merge.
// A merge of two empty lists raises no item_stall and produces no result beat.
// Reset is synchronous and clears the counts, the overflow flag and the sequencer;
// the list stores hold whatever was written and need no clearing.
// A held result beat does not block appends once the block is idle again.
`timescale 1ns / 1ps

module sorted_list_merge_dedup_unit #(
  parameter int LIST_DEPTH = slmd_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  slmd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output slmd_pkg::result_t result
);
  import slmd_pkg::*;

  // A count must reach the depth itself, whereas an address stops one short.
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count_a, count_b;
  logic [CNT_W-1:0] ia, ib;
  logic [CNT_W-1:0] ia_next, ib_next;
  logic             dropped_flag;

  logic               item_fire;
  logic               full_a, full_b;
  logic               wr_a, wr_b;
  logic [VALUE_W-1:0] head_a, head_b;
  cmp_res_t           cmp;

  logic               avail_a, avail_b;
  logic               take_a, take_b;
  logic [VALUE_W-1:0] pick;
  logic               out_free;
  logic               emit;
  logic               done;

  assign item_stall = (state != ST_IDLE);
  assign item_fire  = item_valid && !item_stall;

  assign full_a = (count_a == CNT_W'(LIST_DEPTH));
  assign full_b = (count_b == CNT_W'(LIST_DEPTH));
  assign wr_a   = item_fire && (item.cmd == CMD_APPEND_A) && !full_a;
  assign wr_b   = item_fire && (item.cmd == CMD_APPEND_B) && !full_b;

  slmd_list_ram #(
    .DEPTH  (LIST_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a[ADDR_W-1:0]),
    .wr_data (item.value),
    .rd_addr (ia[ADDR_W-1:0]),
    .rd_data (head_a)
  );

  slmd_list_ram #(
    .DEPTH  (LIST_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b[ADDR_W-1:0]),
    .wr_data (item.value),
    .rd_addr (ib[ADDR_W-1:0]),
    .rd_data (head_b)
  );

  slmd_cmp u_cmp (
    .head_a (head_a),
    .head_b (head_b),
    .res    (cmp)
  );

  // Head selection. With both lists live the smaller head goes out; equal heads
  // go out once and both lists step on. Once one list runs dry the other drains.
  always_comb begin
    avail_a = (ia < count_a);
    avail_b = (ib < count_b);
    take_a  = 1'b0;
    take_b  = 1'b0;
    pick    = head_a;
    if (avail_a && avail_b) begin
      if (cmp.b_less) begin
        take_b = 1'b1;
        pick   = head_b;
      end else if (cmp.a_less) begin
        take_a = 1'b1;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (avail_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
      pick   = head_b;
    end
  end

  // The output register can take a beat when it is empty or being drained now.
  assign out_free = !result_valid || !result_stall;
  assign emit     = (state == ST_EMIT) && out_free;

  assign ia_next = take_a ? ia + CNT_W'(1) : ia;
  assign ib_next = take_b ? ib + CNT_W'(1) : ib;
  // Indices never pass their counts, so equality marks an exhausted list.
  assign done    = (ia_next == count_a) && (ib_next == count_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_fire && (item.cmd == CMD_MERGE) &&
            ((count_a != '0) || (count_b != '0))) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = done ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      dropped_flag <= 1'b0;
      ia           <= '0;
      ib           <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (item_fire) begin
        unique case (item.cmd)
          CMD_APPEND_A: begin
            if (full_a) begin
              dropped_flag <= 1'b1;
            end else begin
              count_a <= count_a + CNT_W'(1);
            end
          end
          CMD_APPEND_B: begin
            if (full_b) begin
              dropped_flag <= 1'b1;
            end else begin
              count_b <= count_b + CNT_W'(1);
            end
          end
          CMD_MERGE: begin
            ia <= '0;
            ib <= '0;
          end
          default: begin
          end
        endcase
      end

      if (emit) begin
        ia <= ia_next;
        ib <= ib_next;
      end

      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload; qualified by result_valid, so it needs no reset.
  always_ff @(posedge clk) begin
    if (emit) begin
      result.merged_value <= pick;
      result.last         <= done;
      result.overflow     <= dropped_flag;
    end
  end

endmodule

// ===== hdl/slmd_checker.sv =====
// Port-level checks on the merge unit's sequencing, bound to the top level.
`timescale 1ns / 1ps

module slmd_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input slmd_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input slmd_pkg::result_t result
);
  import slmd_pkg::*;

  // A stalled result beat stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // The block only turns busy on an accepted merge.
  assert property (@(posedge clk) disable iff (rst)
    $rose(item_stall) && $past(!rst) |-> $past(item_valid && item.cmd == CMD_MERGE))
    else $error("item_stall rose without a merge");

  // A beat that is not the last is taken while its merge is still running.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |-> item_stall)
    else $error("merge ended before its last beat");

  // The block returns to accepting items just after putting out the last beat.
  assert property (@(posedge clk) disable iff (rst)
    $fell(item_stall) && $past(!rst) |-> result_valid && result.last)
    else $error("block went idle without a last beat");

  // The overflow report is sticky from one beat to the next.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(!rst) && $past(result_valid && result.overflow)
      |-> result.overflow)
    else $error("overflow flag cleared without reset");

endmodule

bind sorted_list_merge_dedup_unit slmd_checker u_slmd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== test/tb_sorted_list_merge_dedup_unit.sv =====
// Self-checking testbench for the sorted list merge unit, predicting every merge from shadow lists.
`timescale 1ns / 1ps

module tb_sorted_list_merge_dedup_unit;
  import slmd_pkg::*;

  // The block is built at its default depth, so each list holds 32 values and a
  // merge of two full lists produces at most 64 result beats.
  localparam int DEPTH = DEFAULT_LIST_DEPTH;

  // Command code 3 has no meaning; the block must swallow it without a trace.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Number of random beats that do something (unused commands are not counted).
  localparam int RANDOM_ITEMS = 260;

  // After this many result beats the receiver stops taking results for a long
  // stretch, so that a merge backs up and the item channel is stalled.
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES = 400;

  // The tail after the last expected beat allows for one whole merge of two full
  // lists, with a fetch and an emit state per result beat, and a margin.
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

  // The longest correct stretch with no beat on either channel is the long
  // hold above plus a sender gap, so this limit is several times that.
  localparam int IDLE_LIMIT = 4000;

  // Receiver behaviour: flowing freely, stalling half the time, or mostly stalled.
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_PATCHY,
    FLOW_CHOKED
  } flow_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  sorted_list_merge_dedup_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's state, updated as each item beat is accepted.
  logic signed [VALUE_W-1:0] shadow_a [DEPTH];
  logic signed [VALUE_W-1:0] shadow_b [DEPTH];
  int   fill_a = 0;
  int   fill_b = 0;
  logic overflow_seen = 1'b0;

  // Result beats predicted but not yet seen, oldest first.
  result_t merged_beats_due[$];

  // Item beats waiting to be offered, filled once at the start of the run.
  item_t items_pending[$];

  // How far each list will have been filled once the queued items are applied;
  // the stimulus uses this to place the largest value in each list's last slot.
  int queued_a = 0;
  int queued_b = 0;

  int      errors = 0;
  int      beats_seen = 0;
  result_t due_beat;

  int    burst_left;
  int    gap_left;
  int    hold_left;
  int    mode_left;
  flow_t flow_mode;
  int    quiet_cycles;

  // Applies one accepted item beat to the shadow lists and, for a merge, queues
  // the merged sequence. Equal heads give one beat and advance both lists; once
  // one list runs out the other's tail follows. The final beat carries last.
  task automatic predict_item(input item_t it);
    int ia;
    int ib;
    logic signed [VALUE_W-1:0] pick;
    result_t held;
    bit have_held;
    ia = 0;
    ib = 0;
    have_held = 1'b0;
    held = '0;
    case (it.cmd)
      CMD_APPEND_A: begin
        if (fill_a < DEPTH) begin
          shadow_a[fill_a] = it.value;
          fill_a++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (fill_b < DEPTH) begin
          shadow_b[fill_b] = it.value;
          fill_b++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      CMD_MERGE: begin
        while (ia < fill_a || ib < fill_b) begin
          if (ia == fill_a) begin
            pick = shadow_b[ib];
            ib++;
          end else if (ib == fill_b) begin
            pick = shadow_a[ia];
            ia++;
          end else if (shadow_b[ib] < shadow_a[ia]) begin
            pick = shadow_b[ib];
            ib++;
          end else if (shadow_a[ia] < shadow_b[ib]) begin
            pick = shadow_a[ia];
            ia++;
          end else begin
            pick = shadow_a[ia];
            ia++;
            ib++;
          end
          // Hold each beat back by one so the final one can be marked last.
          if (have_held) begin
            merged_beats_due.push_back(held);
          end
          held.merged_value = pick;
          held.last = 1'b0;
          held.overflow = overflow_seen;
          have_held = 1'b1;
        end
        if (have_held) begin
          held.last = 1'b1;
          merged_beats_due.push_back(held);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_item(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
    item_t it;
    it.cmd = c;
    it.value = v;
    items_pending.push_back(it);
    if (c == CMD_APPEND_A && queued_a < DEPTH) begin
      queued_a++;
    end
    if (c == CMD_APPEND_B && queued_b < DEPTH) begin
      queued_b++;
    end
  endtask

  // Sender: offers queued beats in bursts of random length separated by random
  // gaps, some of them empty so that long back-to-back runs occur as well.
  // A beat stays on the bus unchanged until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_item(item);
      end
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (items_pending.size() != 0) begin
          item <= items_pending.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted result beat against the oldest prediction,
  // then decides the stall for the next cycle. The stall pattern switches
  // between free flow, patchy and choked spells of random length, and once in
  // the run a long hold lets the block fill up behind a merge.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
      flow_mode <= FLOW_FREE;
    end else begin
      if (result_valid && !result_stall) begin
        beats_seen++;
        if (merged_beats_due.size() == 0) begin
          $error("result beat with no merge outstanding: merged_value %0d",
                 result.merged_value);
          errors++;
        end else begin
          due_beat = merged_beats_due.pop_front();
          if (result.merged_value !== due_beat.merged_value) begin
            $error("merged_value: expected %0d, got %0d",
                   due_beat.merged_value, result.merged_value);
            errors++;
          end
          if (result.last !== due_beat.last) begin
            $error("last: expected %0b, got %0b", due_beat.last, result.last);
            errors++;
          end
          if (result.overflow !== due_beat.overflow) begin
            $error("overflow: expected %0b, got %0b", due_beat.overflow, result.overflow);
            errors++;
          end
        end
      end

      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (result_valid && !result_stall && beats_seen == HOLD_AT_BEAT) begin
        hold_left <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          flow_mode <= flow_t'($urandom_range(0, 2));
          mode_left <= $urandom_range(8, 60);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (flow_mode)
          FLOW_FREE:   result_stall <= 1'b0;
          FLOW_PATCHY: result_stall <= ($urandom_range(0, 1) == 1);
          default:     result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: a run in which neither channel moves a beat for too long has hung.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int counted;
    int roll;
    int room;
    int cursor;
    logic [CMD_W-1:0] side;
    logic signed [VALUE_W-1:0] v;

    // Directed opening: a merge of two empty lists, the unused command, the
    // most negative value on its own and then equal in both lists, mixed
    // signs, a tail of B after A runs out and a tail of A after B runs out.
    queue_item(CMD_MERGE, 32'sh0);
    queue_item(CMD_UNUSED, 32'sh5A5A_5A5A);
    queue_item(CMD_APPEND_A, VAL_MIN);
    queue_item(CMD_MERGE, 32'sh0);
    queue_item(CMD_APPEND_B, VAL_MIN);
    queue_item(CMD_MERGE, VAL_MAX);
    queue_item(CMD_APPEND_A, -32'sd5);
    queue_item(CMD_APPEND_B, -32'sd1);
    queue_item(CMD_APPEND_B, 32'sd0);
    queue_item(CMD_APPEND_A, 32'sd0);
    queue_item(CMD_MERGE, 32'sh0);
    queue_item(CMD_APPEND_B, 32'sd7);
    queue_item(CMD_MERGE, 32'sh0);
    queue_item(CMD_APPEND_A, 32'sd100);
    queue_item(CMD_MERGE, VAL_MIN);
    queue_item(CMD_UNUSED, -32'sd1);
    queue_item(CMD_MERGE, 32'sh0);

    // Random part. Most appends continue both lists in ascending order from
    // one shared cursor, which often stands still so that the heads meet with
    // equal values. The last slot of each list takes the largest value. Now
    // and then a random word is appended instead, and once a list is full all
    // its appends carry random words and are dropped, which sets the sticky
    // overflow flag seen on every later merge.
    counted = 0;
    cursor = 101;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_item(CMD_UNUSED, $urandom);
      end else begin
        counted++;
        if (roll < 26) begin
          queue_item(CMD_MERGE, $urandom);
        end else begin
          side = ($urandom_range(0, 1) == 0) ? CMD_APPEND_A : CMD_APPEND_B;
          room = (side == CMD_APPEND_A) ? DEPTH - queued_a : DEPTH - queued_b;
          if (room == 0 || $urandom_range(0, 19) == 0) begin
            v = $urandom;
          end else if (room == 1) begin
            v = VAL_MAX;
          end else begin
            v = cursor;
            roll = $urandom_range(0, 9);
            if (roll >= 4 && roll < 9) begin
              cursor += $urandom_range(1, 3);
            end else if (roll == 9) begin
              cursor += $urandom_range(4, 1 << 22);
            end
          end
          queue_item(side, v);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Wait until every item has been taken and every predicted beat has come,
    // then give the block time to show any beat it should not produce.
    while (items_pending.size() != 0 || item_valid || merged_beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/slmd_pkg.sv
hdl/slmd_list_ram.sv
hdl/slmd_cmp.sv
hdl/sorted_list_merge_dedup_unit.sv
hdl/slmd_checker.sv
test/tb_sorted_list_merge_dedup_unit.sv
